FILE: hdl/sgt_pkg.sv
package sgt_pkg;

  localparam logic [15:0] THRESHOLD_RST = 16'd6000;
  localparam logic [3:0]  REVERSALS_RST = 4'd3;
  localparam logic [15:0] WINDOW_RST    = 16'd800;
  localparam logic [15:0] COOLDOWN_RST  = 16'd1500;
  localparam logic [15:0] GAIN_RST      = 16'd655;
  localparam logic [31:0] AVERAGE_RST   = 32'h4000_0000;

  localparam logic [3:0]  SQ_LAST   = 4'd2;
  localparam logic [3:0]  ROOT_LAST = 4'd15;
  localparam logic [7:0]  COUNT_MAX = 8'hFF;

  typedef enum logic [2:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_REVERSALS = 3'd1,
    CFG_WINDOW    = 3'd2,
    CFG_COOLDOWN  = 3'd3,
    CFG_GAIN      = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2
  } dir_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_DIFF,
    ST_MUL,
    ST_AVG,
    ST_EVAL,
    ST_DECIDE,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic       load;
    logic       sq_step;
    logic       root_step;
    logic       diff;
    logic       mul;
    logic       avg;
    logic       eval;
    logic       decide;
    logic       out_load;
    logic [3:0] step;
  } cmd_t;

endpackage

FILE: hdl/sgt_chan_if.sv
interface sgt_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic        [31:0] time_ms;
  logic        [15:0] audio_rms;

  modport source (output valid, accel_x, accel_y, accel_z, time_ms, audio_rms,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, time_ms, audio_rms,
                output ready);
endinterface

interface sgt_out_if;
  logic        valid;
  logic        ready;
  logic        mic_enabled;
  logic        mic_toggled;
  logic [15:0] gated_rms;

  modport source (output valid, mic_enabled, mic_toggled, gated_rms, input ready);
  modport sink (input valid, mic_enabled, mic_toggled, gated_rms, output ready);
endinterface

FILE: hdl/sgt_ctrl.sv
module sgt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output sgt_pkg::cmd_t cmd
);

  sgt_pkg::state_t state_r, state_nxt;
  logic [3:0]      cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == sgt_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sgt_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.step  = cnt_r;
    unique case (state_r)
      sgt_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = sgt_pkg::ST_SQ;
        end
      end
      sgt_pkg::ST_SQ: begin
        cmd.sq_step = 1'b1;
        if (cnt_r == sgt_pkg::SQ_LAST) begin
          cnt_nxt   = '0;
          state_nxt = sgt_pkg::ST_ROOT;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      sgt_pkg::ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt_r == sgt_pkg::ROOT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = sgt_pkg::ST_DIFF;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      sgt_pkg::ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = sgt_pkg::ST_MUL;
      end
      sgt_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = sgt_pkg::ST_AVG;
      end
      sgt_pkg::ST_AVG: begin
        cmd.avg   = 1'b1;
        state_nxt = sgt_pkg::ST_EVAL;
      end
      sgt_pkg::ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sgt_pkg::ST_DECIDE;
      end
      sgt_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = sgt_pkg::ST_WRITE;
      end
      sgt_pkg::ST_WRITE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = sgt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sgt_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_load || (out_valid_r && !out_ready);

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == sgt_pkg::ST_SQ && cnt_r == 4'd0))
    else $error("accepted beat did not start the squaring steps");

  a_root_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sgt_pkg::ST_ROOT && cnt_r != sgt_pkg::ROOT_LAST)
      |=> state_r == sgt_pkg::ST_ROOT)
    else $error("square root left before its last step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.out_load)
    else $error("output register loaded while its beat waits");

endmodule

FILE: hdl/sgt_datapath.sv
module sgt_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic        [2:0]  cfg_index,
  input  logic        [15:0] cfg_data,
  input  sgt_pkg::cmd_t      cmd,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic        [31:0] time_ms,
  input  logic        [15:0] audio_rms,
  output logic               mic_enabled,
  output logic               mic_toggled,
  output logic        [15:0] gated_rms
);

  logic [15:0] thr_r, window_r, cooldown_r, gain_r;
  logic [3:0]  needed_r;

  logic signed [15:0] ax_r, ay_r, az_r;
  logic        [31:0] now_r;
  logic        [15:0] rms_r;

  logic [31:0] sum_r, rem_r, res_r;
  logic        neg_r, dpos_r, cool_ok_r;
  logic [31:0] adiff_r, adyn_r, elapsed_r;
  logic [47:0] prod_r;

  logic [31:0]     avg_r, avg_nxt;
  sgt_pkg::dir_t   last_r, last_nxt;
  logic [7:0]      cnt_r, cnt_nxt;
  logic [31:0]     frt_r, frt_nxt;
  logic [31:0]     cool_end_r, cool_end_nxt;
  logic            mic_on_r, mic_on_nxt;
  logic            tog_r, tog_nxt;

  logic        out_mic_r, out_tog_r;
  logic [15:0] out_rms_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= sgt_pkg::THRESHOLD_RST;
      needed_r   <= sgt_pkg::REVERSALS_RST;
      window_r   <= sgt_pkg::WINDOW_RST;
      cooldown_r <= sgt_pkg::COOLDOWN_RST;
      gain_r     <= sgt_pkg::GAIN_RST;
    end else if (cfg_we) begin
      unique case (sgt_pkg::cfg_idx_t'(cfg_index))
        sgt_pkg::CFG_THRESHOLD: thr_r      <= cfg_data;
        sgt_pkg::CFG_REVERSALS: needed_r   <= cfg_data[3:0];
        sgt_pkg::CFG_WINDOW:    window_r   <= cfg_data;
        sgt_pkg::CFG_COOLDOWN:  cooldown_r <= cfg_data;
        sgt_pkg::CFG_GAIN:      gain_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r  <= accel_x;
      ay_r  <= accel_y;
      az_r  <= accel_z;
      now_r <= time_ms;
      rms_r <= audio_rms;
    end
  end

  logic signed [15:0] sq_op;
  logic signed [31:0] sq_prod;
  logic        [31:0] sum_nxt;

  always_comb begin
    case (cmd.step[1:0])
      2'd0:    sq_op = ax_r;
      2'd1:    sq_op = ay_r;
      default: sq_op = az_r;
    endcase
  end

  assign sq_prod = sq_op * sq_op;
  assign sum_nxt = ((cmd.step[1:0] == 2'd0) ? 32'd0 : sum_r) + $unsigned(sq_prod);

  always_ff @(posedge clk) begin
    if (cmd.sq_step) begin
      sum_r <= sum_nxt;
    end
  end

  logic [31:0] rt_v, rt_res, rt_bit, rt_trial, rem_nxt, res_nxt;

  always_comb begin
    rt_v     = (cmd.step == 4'd0) ? sum_r : rem_r;
    rt_res   = (cmd.step == 4'd0) ? 32'd0 : res_r;
    rt_bit   = 32'd1 << {~cmd.step, 1'b0};
    rt_trial = rt_res + rt_bit;
    if (rt_v >= rt_trial) begin
      rem_nxt = rt_v - rt_trial;
      res_nxt = (rt_res >> 1) + rt_bit;
    end else begin
      rem_nxt = rt_v;
      res_nxt = rt_res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.root_step) begin
      rem_r <= rem_nxt;
      res_r <= res_nxt;
    end
  end

  logic [31:0] mag_q;
  assign mag_q = {res_r[15:0], 16'h0000};

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      neg_r   <= (mag_q < avg_r);
      adiff_r <= (mag_q < avg_r) ? (avg_r - mag_q) : (mag_q - avg_r);
    end
    if (cmd.mul) begin
      prod_r <= adiff_r * gain_r;
    end
    if (cmd.eval) begin
      dpos_r    <= (mag_q > avg_r);
      adyn_r    <= (mag_q > avg_r) ? (mag_q - avg_r) : (avg_r - mag_q);
      cool_ok_r <= (now_r > cool_end_r);
      elapsed_r <= now_r - frt_r;
    end
  end

  logic [47:0] prod_rnd;
  logic [31:0] step_mag;

  assign prod_rnd = prod_r + {32'h0, (neg_r ? 16'hFFFF : 16'h0000)};
  assign step_mag = prod_rnd[47:16];

  always_comb begin
    avg_nxt = avg_r;
    if (cmd.avg) begin
      avg_nxt = neg_r ? (avg_r - step_mag) : (avg_r + step_mag);
    end
  end

  logic          shake, rev, first, toggle, expire;
  sgt_pkg::dir_t dir, last_t;
  logic [31:0]   elapsed_d;
  logic [7:0]    cnt_inc, cnt_t;

  always_comb begin
    shake     = cool_ok_r && (adyn_r > {thr_r, 16'h0000});
    dir       = dpos_r ? sgt_pkg::DIR_POS : sgt_pkg::DIR_NEG;
    rev       = shake && (dir != last_r) && (last_r != sgt_pkg::DIR_NONE);
    first     = rev && (cnt_r == 8'd0);
    elapsed_d = first ? 32'd0 : elapsed_r;
    cnt_inc   = (rev && cnt_r != sgt_pkg::COUNT_MAX) ? (cnt_r + 8'd1) : cnt_r;
    toggle    = rev && (cnt_inc >= {4'h0, needed_r}) && (elapsed_d < {16'h0, window_r});
    cnt_t     = toggle ? 8'd0 : cnt_inc;
    last_t    = shake ? dir : last_r;
    expire    = (cnt_t != 8'd0) && (elapsed_d > {16'h0, window_r});

    last_nxt     = last_r;
    cnt_nxt      = cnt_r;
    frt_nxt      = frt_r;
    cool_end_nxt = cool_end_r;
    mic_on_nxt   = mic_on_r;
    tog_nxt      = tog_r;
    if (cmd.decide) begin
      cnt_nxt      = expire ? 8'd0 : cnt_t;
      last_nxt     = expire ? sgt_pkg::DIR_NONE : last_t;
      frt_nxt      = first ? now_r : frt_r;
      cool_end_nxt = toggle ? (now_r + {16'h0, cooldown_r}) : cool_end_r;
      mic_on_nxt   = mic_on_r ^ toggle;
      tog_nxt      = toggle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r      <= sgt_pkg::AVERAGE_RST;
      last_r     <= sgt_pkg::DIR_NONE;
      cnt_r      <= '0;
      frt_r      <= '0;
      cool_end_r <= '0;
      mic_on_r   <= 1'b1;
      tog_r      <= 1'b0;
    end else begin
      avg_r      <= avg_nxt;
      last_r     <= last_nxt;
      cnt_r      <= cnt_nxt;
      frt_r      <= frt_nxt;
      cool_end_r <= cool_end_nxt;
      mic_on_r   <= mic_on_nxt;
      tog_r      <= tog_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_mic_r <= mic_on_r;
      out_tog_r <= tog_r;
      out_rms_r <= mic_on_r ? rms_r : 16'h0000;
    end
  end

  assign mic_enabled = out_mic_r;
  assign mic_toggled = out_tog_r;
  assign gated_rms   = out_rms_r;

  a_mic_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.decide |=> $stable(mic_on_r))
    else $error("mic enable changed outside the decision step");

  a_gate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (out_mic_r || out_rms_r == 16'h0000))
    else $error("level passed while the mic is off");

  a_toggle_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.decide && toggle) |=> cnt_r == 8'd0)
    else $error("reversal count kept after a toggle");

endmodule

FILE: hdl/shake_gesture_toggle_unit.sv
// Shake-gesture mic toggle: one accelerometer beat in, one result beat out.
// Each accepted beat runs through 3 squaring steps on one shared 16x16
// multiplier, 16 steps of the bit-pair square root, then difference, gain
// multiply, average update, evaluation and decision, and is loaded into the
// output register once the result side is not stalled. The next beat is
// taken in the idle cycle after the result sits in the output register, even
// while it waits to be taken, so a new beat is not taken before the last one
// has been loaded.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the
// user writes them only while the unit is idle, which the unit does not enforce.
module shake_gesture_toggle_unit (
  input  logic        clk,
  input  logic        rst_n,
  sgt_in_if.sink      in_chan,
  sgt_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  sgt_pkg::cmd_t cmd;

  sgt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  sgt_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .accel_x     (in_chan.accel_x),
    .accel_y     (in_chan.accel_y),
    .accel_z     (in_chan.accel_z),
    .time_ms     (in_chan.time_ms),
    .audio_rms   (in_chan.audio_rms),
    .mic_enabled (out_chan.mic_enabled),
    .mic_toggled (out_chan.mic_toggled),
    .gated_rms   (out_chan.gated_rms)
  );

endmodule

FILE: dv/tb_shake_gesture_toggle_unit.sv
module tb_shake_gesture_toggle_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        en;
    logic        tog;
    logic [15:0] rms;
  } mic_result_t;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int          DRAIN_CYCLES = 40;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  sgt_in_if  in_chan ();
  sgt_out_if out_chan ();

  shake_gesture_toggle_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  int          send_idle_pct;
  int          recv_idle_pct;
  int          n_fail = 0;
  int unsigned cycle_cnt = 0;

  mic_result_t expected_results[$];
  mic_result_t head_result;

  logic [15:0] thr_cfg;
  logic [3:0]  need_cfg;
  logic [15:0] win_cfg;
  logic [15:0] cool_cfg;
  logic [15:0] gain_cfg;

  logic [31:0]   avg_q;
  sgt_pkg::dir_t prev_dir;
  logic [7:0]    rev_cnt;
  logic [31:0]   rev_start;
  logic [31:0]   quiet_until;
  logic          mic_on;

  logic [31:0] t_ms;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_results.size() == 0) begin
        n_fail++;
        $error("result beat with no expected result waiting");
      end else begin
        head_result = expected_results.pop_front();
        if (out_chan.mic_enabled !== head_result.en) begin
          n_fail++;
          $error("mic_enabled: expected %0d, actual %0d", head_result.en,
                 out_chan.mic_enabled);
        end
        if (out_chan.mic_toggled !== head_result.tog) begin
          n_fail++;
          $error("mic_toggled: expected %0d, actual %0d", head_result.tog,
                 out_chan.mic_toggled);
        end
        if (out_chan.gated_rms !== head_result.rms) begin
          n_fail++;
          $error("gated_rms: expected %0d, actual %0d", head_result.rms,
                 out_chan.gated_rms);
        end
      end
    end
  end

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int i = 15; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic mic_result_t predict_gesture(input logic signed [15:0] ax, ay, az,
                                                  input logic [31:0] now,
                                                  input logic [15:0] rms);
    longint        sq;
    longint        mag_q;
    longint        diff;
    longint        dyn;
    longint        dyn_abs;
    sgt_pkg::dir_t dir;
    mic_result_t   r;
    sq = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
    mag_q = longint'(root_floor(sq)) << 16;
    diff = mag_q - longint'(avg_q);
    avg_q = 32'(longint'(avg_q) + ((diff * longint'(gain_cfg)) >>> 16));
    dyn = mag_q - longint'(avg_q);
    dyn_abs = (dyn < 0) ? -dyn : dyn;
    r.tog = 1'b0;
    if (now > quiet_until) begin
      if (dyn_abs > (longint'(thr_cfg) << 16)) begin
        dir = (dyn > 0) ? sgt_pkg::DIR_POS : sgt_pkg::DIR_NEG;
        if (dir != prev_dir && prev_dir != sgt_pkg::DIR_NONE) begin
          if (rev_cnt == 0) rev_start = now;
          if (rev_cnt != sgt_pkg::COUNT_MAX) rev_cnt++;
          if (rev_cnt >= need_cfg && 32'(now - rev_start) < 32'(win_cfg)) begin
            mic_on = ~mic_on;
            r.tog = 1'b1;
            quiet_until = now + 32'(cool_cfg);
            rev_cnt = 0;
          end
        end
        prev_dir = dir;
      end
    end
    if (rev_cnt != 0 && 32'(now - rev_start) > 32'(win_cfg)) begin
      rev_cnt = 0;
      prev_dir = sgt_pkg::DIR_NONE;
    end
    r.en = mic_on;
    r.rms = mic_on ? rms : 16'd0;
    return r;
  endfunction

  function automatic logic [15:0] pick16(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic logic signed [15:0] small_axis();
    return 16'(int'($urandom_range(3000)) - 1500);
  endfunction

  task automatic set_idle(input int sender_pct, input int receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
  endtask

  task automatic send_sample(input logic signed [15:0] ax, ay, az,
                             input logic [31:0] now, input logic [15:0] rms);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.accel_x   <= ax;
    in_chan.accel_y   <= ay;
    in_chan.accel_z   <= az;
    in_chan.time_ms   <= now;
    in_chan.audio_rms <= rms;
    do @(posedge clk); while (!in_chan.ready);
    expected_results.push_back(predict_gesture(ax, ay, az, now, rms));
  endtask

  // high: one strong axis, low: near zero; sign and content random
  task automatic send_shake(input bit high, input logic [31:0] now);
    logic signed [15:0] big;
    if (high) begin
      big = 16'($urandom_range(32767, 20000));
      if ($urandom_range(1)) big = -big;
      send_sample(big, small_axis(), small_axis(), now, 16'($urandom));
    end else begin
      send_sample(small_axis(), small_axis(), small_axis(), now, 16'($urandom));
    end
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input sgt_pkg::cfg_idx_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] thr, input logic [3:0] need,
                                input logic [15:0] win, input logic [15:0] cool,
                                input logic [15:0] gain);
    wait_drained();
    write_reg(sgt_pkg::CFG_THRESHOLD, thr);
    write_reg(sgt_pkg::CFG_REVERSALS, 16'(need));
    write_reg(sgt_pkg::CFG_WINDOW, win);
    write_reg(sgt_pkg::CFG_COOLDOWN, cool);
    write_reg(sgt_pkg::CFG_GAIN, gain);
    cfg_we   <= 1'b0;
    thr_cfg  = thr;
    need_cfg = need;
    win_cfg  = win;
    cool_cfg = cool;
    gain_cfg = gain;
  endtask

  task automatic run_traffic(input int n);
    int sent;
    int len;
    bit hi;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(3) != 0) begin
        len = $urandom_range(12, 2);
        hi = 1'($urandom_range(1));
        repeat (len) begin
          t_ms += 32'($urandom_range(200, 1));
          send_shake(hi, t_ms);
          hi = ~hi;
          sent++;
        end
      end else begin
        case ($urandom_range(3))
          0: t_ms = $urandom();
          1: t_ms += 32'($urandom_range(5000));
          default: t_ms += 32'($urandom_range(200));
        endcase
        send_sample(16'($urandom), 16'($urandom), 16'($urandom), t_ms, 16'($urandom));
        sent++;
      end
      if ($urandom_range(99) == 0) wait_drained();
    end
  endtask

  task automatic test_field_extremes();
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 32'd0, 16'h0000);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'hFFFF_FFFF, 16'hFFFF);
  endtask

  task automatic test_shake_toggle();
    for (int k = 0; k < 4; k++) begin
      send_sample((k % 2) ? 16'sd0 : 16'sd32767, 16'sd0, 16'sd0, 32'(100 + 40 * k),
                  16'(1000 + k));
    end
  endtask

  task automatic test_cooldown();
    for (int k = 0; k < 5; k++) begin
      send_sample((k % 2) ? 16'sd0 : 16'sd32767, 16'sd0, 16'sd0,
                  (k < 2) ? 32'(260 + 40 * k) : 32'(1720 + 40 * k), 16'(2000 + k));
    end
  endtask

  task automatic test_window_expiry();
    int unsigned stamps [8];
    stamps = '{3400, 3440, 4500, 4540, 5000, 5800, 5800, 5801};
    for (int k = 0; k < 8; k++) begin
      send_sample((k % 2) ? 16'sd0 : 16'sd32767, 16'sd0, 16'sd0, stamps[k], 16'(3000 + k));
    end
  endtask

  task automatic test_time_wrap();
    for (int k = 0; k < 5; k++) begin
      send_sample((k % 2) ? 16'sd0 : 16'sd32767, 16'sd0, 16'sd0,
                  32'hFFFF_FF00 + 32'(40 * k), 16'(4000 + k));
    end
    send_sample(16'sd0, 16'sd0, 16'sd0, 32'd16, 16'd4100);
    send_sample(16'sd32767, 16'sd0, 16'sd0, 32'd2000, 16'd4101);
  endtask

  task automatic test_zero_reversals();
    apply_settings(sgt_pkg::THRESHOLD_RST, 4'd0, sgt_pkg::WINDOW_RST, 16'd0,
                   sgt_pkg::GAIN_RST);
    for (int k = 0; k < 3; k++) begin
      send_sample((k % 2) ? 16'sd0 : 16'sd32767, 16'sd0, 16'sd0, 32'(100000 + 40 * k),
                  16'(5000 + k));
    end
  endtask

  task automatic test_random_gestures(input int n_items, input int n_settings);
    for (int s = 0; s < n_settings; s++) begin
      apply_settings(pick16(500, 20000), 4'($urandom_range(15)), pick16(50, 3000),
                     pick16(0, 3000), pick16(0, 8000));
      run_traffic(n_items / n_settings);
    end
  endtask

  task automatic test_count_saturation();
    logic [31:0] t_sat;
    bit          hi;
    // settle the average near mid scale, then freeze it
    apply_settings(16'hFFFF, 4'd15, 16'd0, 16'd0, 16'hFFFF);
    send_sample(16'sd16384, 16'sd0, 16'sd0, t_ms, 16'($urandom));
    apply_settings(16'd1000, 4'd15, 16'd0, 16'd0, 16'd0);
    t_sat = quiet_until + 32'd1;
    hi = 1'b1;
    repeat (270) begin
      send_shake(hi, t_sat);
      hi = ~hi;
    end
  endtask

  task automatic test_config_extremes();
    apply_settings(16'h0000, 4'd0, 16'h0000, 16'h0000, 16'h0000);
    run_traffic(60);
    apply_settings(16'hFFFF, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_traffic(60);
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = sgt_pkg::CFG_THRESHOLD;
    cfg_data           = '0;
    in_chan.valid      = 1'b0;
    in_chan.accel_x    = '0;
    in_chan.accel_y    = '0;
    in_chan.accel_z    = '0;
    in_chan.time_ms    = '0;
    in_chan.audio_rms  = '0;
    thr_cfg            = sgt_pkg::THRESHOLD_RST;
    need_cfg           = sgt_pkg::REVERSALS_RST;
    win_cfg            = sgt_pkg::WINDOW_RST;
    cool_cfg           = sgt_pkg::COOLDOWN_RST;
    gain_cfg           = sgt_pkg::GAIN_RST;
    avg_q              = sgt_pkg::AVERAGE_RST;
    prev_dir           = sgt_pkg::DIR_NONE;
    rev_cnt            = '0;
    rev_start          = '0;
    quiet_until        = '0;
    mic_on             = 1'b1;
    t_ms               = 32'd200000;
    set_idle(23, 45);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_shake_toggle();
    test_cooldown();
    test_window_expiry();
    test_time_wrap();
    test_zero_reversals();

    test_random_gestures(550, 2);

    set_idle(45, 23);
    test_count_saturation();
    test_random_gestures(280, 2);

    set_idle(0, 0);
    test_config_extremes();
    test_random_gestures(430, 2);

    wait_drained();
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
